### rtl/pip_pkg.sv
// ----------------------------------------------------------------------------
// pip_pkg: shared types for the point-in-polygon crossing-number test
// Beat structs for the two channels, item codes and the token control word
// that travels along the cell chain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pip_pkg;

	// Item codes carried in the cmd field
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_TEST = 1'b1;

	// Width of the reported crossing count (wraps modulo 16)
	localparam int CNT_BITS = 4;

	// Input beat
	typedef struct packed {
		logic               cmd;
		logic [3:0]         vertex_index;
		logic signed [15:0] coord_x;
		logic signed [15:0] coord_y;
	} in_t;

	// Result beat
	typedef struct packed {
		logic                inside_res;
		logic [CNT_BITS-1:0] crossings;
	} out_t;

	// Control word that follows a test point along the chain
	typedef struct packed {
		logic                valid;
		logic                par;
		logic [CNT_BITS-1:0] cnt;
	} ctl_t;

endpackage

### rtl/pip_cell.sv
// ----------------------------------------------------------------------------
// pip_cell: one vertex of the polygon and the edge that leaves it
// Holds vertex i, sees vertex i+1 from its neighbour, and tests that edge
// against the point passing through. Products are registered here; the
// compare is finished as the hit bit seen by the next cell.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pip_cell #(
	parameter int COORD_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// vertex write
	input  logic                         wr_en,
	input  logic signed [COORD_BITS-1:0] wr_x,
	input  logic signed [COORD_BITS-1:0] wr_y,
	// own vertex out, neighbour vertex in
	output logic signed [COORD_BITS-1:0] vx,
	output logic signed [COORD_BITS-1:0] vy,
	input  logic signed [COORD_BITS-1:0] nxt_x,
	input  logic signed [COORD_BITS-1:0] nxt_y,
	// point token from the previous cell
	input  pip_pkg::ctl_t                tok_in,
	input  logic                         hit_in,
	input  logic signed [COORD_BITS-1:0] px_in,
	input  logic signed [COORD_BITS-1:0] py_in,
	// point token to the next cell
	output pip_pkg::ctl_t                tok_out,
	output logic                         hit_out,
	output logic signed [COORD_BITS-1:0] px_out,
	output logic signed [COORD_BITS-1:0] py_out
);

	localparam int DW = COORD_BITS + 1;
	localparam int PW = 2 * DW;

	logic signed [COORD_BITS-1:0] vx_q, vy_q;
	logic signed [DW-1:0]         dx, dy, rx, ry;
	logic signed [PW-1:0]         p1_d, p2_d;
	logic signed [PW-1:0]         p1_s1, p2_s1;
	logic                         cross_d;
	logic                         cross_s1, dyneg_s1;
	pip_pkg::ctl_t                tok_q;
	logic signed [COORD_BITS-1:0] px_q, py_q;

	// vertex storage, undefined until written
	always_ff @(posedge clk) begin
		if (wr_en) begin
			vx_q <= wr_x;
			vy_q <= wr_y;
		end
	end

	assign vx = vx_q;
	assign vy = vy_q;

	// edge straddles the point's y
	assign cross_d = (vy_q < py_in) ^ (nxt_y < py_in);

	// differences at one extra bit, exact
	assign dx = {nxt_x[COORD_BITS-1], nxt_x} - {vx_q[COORD_BITS-1], vx_q};
	assign dy = {nxt_y[COORD_BITS-1], nxt_y} - {vy_q[COORD_BITS-1], vy_q};
	assign rx = {px_in[COORD_BITS-1], px_in} - {vx_q[COORD_BITS-1], vx_q};
	assign ry = {py_in[COORD_BITS-1], py_in} - {vy_q[COORD_BITS-1], vy_q};

	// cross products: rx*dy against dx*ry
	assign p1_d = rx * dy;
	assign p2_d = dx * ry;

	always_ff @(posedge clk) begin
		p1_s1    <= p1_d;
		p2_s1    <= p2_d;
		cross_s1 <= cross_d;
		dyneg_s1 <= dy[DW-1];
		px_q     <= px_in;
		py_q     <= py_in;
	end

	// left-of decision, sense follows the sign of the y span
	assign hit_out = cross_s1 & (dyneg_s1 ? (p2_s1 < p1_s1) : (p1_s1 < p2_s1));

	// token: fold in the previous cell's hit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q.valid <= tok_in.valid;
			tok_q.par   <= tok_in.par ^ hit_in;
			tok_q.cnt   <= tok_in.cnt + pip_pkg::CNT_BITS'(hit_in);
		end
	end

	assign tok_out = tok_q;
	assign px_out  = px_q;
	assign py_out  = py_q;

endmodule

### rtl/point_in_polygon_test.sv
// ----------------------------------------------------------------------------
// point_in_polygon_test: crossing-number point-in-polygon test
// Path: a load beat writes its cell's vertex register. A test point passes
// the entry register, the VERTICES (default ten) cell registers and the
// output register, walking one cell per cycle. Throughput: a new test waits
// until the last result is in the output register; loads every cycle if idle.
// Reset: arst_n clears control and out_valid; vertex table stays undefined.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module point_in_polygon_test #(
	parameter int VERTICES   = 10,
	parameter int COORD_BITS = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  pip_pkg::in_t   in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output pip_pkg::out_t  out_data
);

	localparam int CB = pip_pkg::CNT_BITS;

	logic signed [COORD_BITS-1:0] cx, cy;
	logic                         in_acc, load_acc, test_acc;
	logic [VERTICES-1:0]          wr_en;

	logic signed [COORD_BITS-1:0] vx [VERTICES];
	logic signed [COORD_BITS-1:0] vy [VERTICES];
	pip_pkg::ctl_t                tok [VERTICES+1];
	logic signed [COORD_BITS-1:0] px  [VERTICES+1];
	logic signed [COORD_BITS-1:0] py  [VERTICES+1];
	logic [VERTICES-1:0]          hit;
	logic [VERTICES:0]            tok_vld;

	pip_pkg::ctl_t                tok_s0;
	logic signed [COORD_BITS-1:0] px_s0, py_s0;

	logic                         busy_q;
	logic                         fin, out_free;
	pip_pkg::out_t                res;
	pip_pkg::out_t                hold_q, out_q;
	logic                         hold_valid_q, out_valid_q;

	// coordinate width conversion
	generate
		if (COORD_BITS <= 16) begin : g_narrow
			assign cx = COORD_BITS'(in_data.coord_x);
			assign cy = COORD_BITS'(in_data.coord_y);
		end else begin : g_wide
			assign cx = COORD_BITS'(in_data.coord_x);
			assign cy = COORD_BITS'(in_data.coord_y);
		end
	endgenerate

	// input handshake
	assign in_ready = !busy_q;
	assign in_acc   = in_valid && in_ready;
	assign load_acc = in_acc && (in_data.cmd == pip_pkg::CMD_LOAD);
	assign test_acc = in_acc && (in_data.cmd == pip_pkg::CMD_TEST);

	// slot decode; out-of-range slots match no cell
	always_comb begin
		for (int i = 0; i < VERTICES; i++) begin
			wr_en[i] = load_acc && (32'(in_data.vertex_index) == 32'(i));
		end
	end

	// chain entry register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_s0 <= '0;
		end else begin
			tok_s0.valid <= test_acc;
			tok_s0.par   <= 1'b0;
			tok_s0.cnt   <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (test_acc) begin
			px_s0 <= cx;
			py_s0 <= cy;
		end
	end

	assign tok[0] = tok_s0;
	assign px[0]  = px_s0;
	assign py[0]  = py_s0;

	// row of vertex cells, cell i tests edge i -> i+1 mod VERTICES
	generate
		for (genvar i = 0; i < VERTICES; i++) begin : g_cell
			localparam int NXT = (i + 1) % VERTICES;
			logic hit_prev;

			if (i == 0) begin : g_first
				assign hit_prev = 1'b0;
			end else begin : g_rest
				assign hit_prev = hit[i-1];
			end

			pip_cell #(
				.COORD_BITS(COORD_BITS)
			) u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.wr_en   (wr_en[i]),
				.wr_x    (cx),
				.wr_y    (cy),
				.vx      (vx[i]),
				.vy      (vy[i]),
				.nxt_x   (vx[NXT]),
				.nxt_y   (vy[NXT]),
				.tok_in  (tok[i]),
				.hit_in  (hit_prev),
				.px_in   (px[i]),
				.py_in   (py[i]),
				.tok_out (tok[i+1]),
				.hit_out (hit[i]),
				.px_out  (px[i+1]),
				.py_out  (py[i+1])
			);
		end
	endgenerate

	always_comb begin
		for (int i = 0; i <= VERTICES; i++) begin
			tok_vld[i] = tok[i].valid;
		end
	end

	// final edge folded in as the token leaves the chain
	assign fin            = tok[VERTICES].valid;
	assign res.inside_res = tok[VERTICES].par ^ hit[VERTICES-1];
	assign res.crossings  = tok[VERTICES].cnt + CB'(hit[VERTICES-1]);

	assign out_free = !out_valid_q || out_ready;

	// busy from test acceptance until its result reaches the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= 1'b0;
			hold_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (test_acc) begin
				busy_q <= 1'b1;
			end else if (out_free && (hold_valid_q || fin)) begin
				busy_q <= 1'b0;
			end

			if (out_free) begin
				out_valid_q  <= hold_valid_q || fin;
				hold_valid_q <= 1'b0;
			end else if (fin) begin
				hold_valid_q <= 1'b1;
			end
		end
	end

	// result payload: skid slot and output register
	always_ff @(posedge clk) begin
		if (fin && !out_free) begin
			hold_q <= res;
		end
		if (out_free) begin
			out_q <= hold_valid_q ? hold_q : res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef NO_ASSERTIONS
	// only one point walks the chain at a time
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(tok_vld) <= 1)
		else $error("more than one test point in the chain");

	// a point in the chain keeps the input closed
	a_busy_chain: assert property (@(posedge clk) disable iff (!arst_n)
		(tok_vld != '0) |-> busy_q)
		else $error("chain active while input open");

	// skid slot is used only behind a full output register
	a_hold_out: assert property (@(posedge clk) disable iff (!arst_n)
		hold_valid_q |-> out_valid_q)
		else $error("skid slot full with output empty");

	// a finished test never lands on a full skid slot
	a_fin_hold: assert property (@(posedge clk) disable iff (!arst_n)
		fin |-> !hold_valid_q)
		else $error("result lost on full skid slot");

	// an accepted test enters the chain next cycle
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		test_acc |=> tok_s0.valid && busy_q)
		else $error("accepted test did not enter the chain");
`endif

endmodule
